### rtl/icc_pkg.sv
// ----------------------------------------------------------------------------
// icc_pkg
// Shared widths, register indexes, scale constants and the divider cell bus.
// ----------------------------------------------------------------------------
package icc_pkg;

    // Iteration limit width and the Q1.24 fraction
    localparam int MAX_BITS   = 16;
    localparam int FRAC_BITS  = 24;
    localparam int QW         = FRAC_BITS + 1;   // holds 0 .. 2^24 inclusive
    localparam int PW         = 2 * QW;
    localparam int COUNT_BITS = 16;
    localparam int CELLS      = QW;              // one quotient bit per cell

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SMOOTH   = 1'd1;
    localparam logic [MAX_BITS-1:0]     MAX_ITER_RST = 16'd255;

    // Smooth palette output scales: 9*255, 15*255, 8.5*255*2
    localparam int SC_W = 13;
    localparam logic [SC_W-1:0] RED_SCALE   = 13'd2295;
    localparam logic [SC_W-1:0] GREEN_SCALE = 13'd3825;
    localparam logic [SC_W-1:0] BLUE_SCALE  = 13'd4335;

    // Word passed from one divider cell to the next
    typedef struct packed {
        logic                valid;
        logic [MAX_BITS-1:0] rem;
        logic [QW-1:0]       quo;
    } t_cell_bus;

endpackage

### rtl/icc_div_cell.sv
// ----------------------------------------------------------------------------
// icc_div_cell
// One restoring-division cell: decide one quotient bit, pass the remainder on.
// ----------------------------------------------------------------------------
module icc_div_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [icc_pkg::MAX_BITS-1:0] i_maxi,
    input  logic                         i_valid,
    input  logic [icc_pkg::MAX_BITS:0]   i_part,
    input  logic [icc_pkg::QW-1:0]       i_quo,
    output icc_pkg::t_cell_bus           o_bus
);

    logic                         w_ge;
    logic [icc_pkg::MAX_BITS:0]   w_diff;
    icc_pkg::t_cell_bus           n_bus;
    icc_pkg::t_cell_bus           r_bus;

    // Compare and subtract the divisor
    always_comb begin
        w_ge        = (i_part >= {1'b0, i_maxi});
        w_diff      = i_part - {1'b0, i_maxi};
        n_bus.valid = i_valid;
        n_bus.rem   = w_ge ? w_diff[icc_pkg::MAX_BITS-1:0]
                           : i_part[icc_pkg::MAX_BITS-1:0];
        n_bus.quo   = {i_quo[icc_pkg::QW-2:0], w_ge};
    end

    // Hold valid under reset, payload free-running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= n_bus.valid;
        end
        r_bus.rem <= n_bus.rem;
        r_bus.quo <= n_bus.quo;
    end

    assign o_bus = r_bus;

endmodule

### rtl/icc_poly.sv
// ----------------------------------------------------------------------------
// icc_poly
// Four-stage palette pipeline: powers of t and 1-t, products, final scale.
// ----------------------------------------------------------------------------
module icc_poly (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_smooth,
    input  logic                   i_valid,
    input  logic [icc_pkg::QW-1:0] i_t,
    output logic                   o_valid,
    output logic [7:0]             o_red,
    output logic [7:0]             o_green,
    output logic [7:0]             o_blue
);

    localparam int QW = icc_pkg::QW;
    localparam int PW = icc_pkg::PW;
    localparam int FB = icc_pkg::FRAC_BITS;
    localparam int SW = QW + icc_pkg::SC_W;

    logic [3:0]    r_vld;
    logic [QW-1:0] r_a_t, r_a_u, r_a_t2, r_a_u2;
    logic [QW-1:0] r_b_t, r_b_u, r_b_t2, r_b_u2, r_b_t3, r_b_u3;
    logic [QW-1:0] r_c_t, r_c_pr, r_c_pg, r_c_pb;
    logic [7:0]    r_red, r_green, r_blue;

    logic [QW-1:0] w_u;
    logic [PW-1:0] w_tt, w_uu, w_t3, w_u3, w_pr, w_pg, w_pb;
    logic [SW-1:0] w_sr, w_sg, w_sb;
    logic [7:0]    n_red, n_green, n_blue;

    // Stage A: squares
    assign w_u  = QW'(1 << FB) - i_t;
    assign w_tt = PW'(i_t) * PW'(i_t);
    assign w_uu = PW'(w_u) * PW'(w_u);
    // Stage B: cubes
    assign w_t3 = PW'(r_a_t2) * PW'(r_a_t);
    assign w_u3 = PW'(r_a_u2) * PW'(r_a_u);
    // Stage C: mixed products
    assign w_pr = PW'(r_b_u)  * PW'(r_b_t3);
    assign w_pg = PW'(r_b_u2) * PW'(r_b_t2);
    assign w_pb = PW'(r_b_u3) * PW'(r_b_t);
    // Stage D: scale to bytes
    assign w_sr = SW'(r_c_pr) * SW'(icc_pkg::RED_SCALE);
    assign w_sg = SW'(r_c_pg) * SW'(icc_pkg::GREEN_SCALE);
    assign w_sb = SW'(r_c_pb) * SW'(icc_pkg::BLUE_SCALE);

    // Pick the palette
    always_comb begin
        if (i_smooth) begin
            n_red   = w_sr[FB+7:FB];
            n_green = w_sg[FB+7:FB];
            n_blue  = w_sb[FB+8:FB+1];
        end else begin
            n_red   = r_c_t[15:8];
            n_green = r_c_t[7:0];
            n_blue  = r_c_t[23:16];
        end
    end

    // Advance valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_a_t   <= i_t;
        r_a_u   <= w_u;
        r_a_t2  <= w_tt[FB+QW-1:FB];
        r_a_u2  <= w_uu[FB+QW-1:FB];
        r_b_t   <= r_a_t;
        r_b_u   <= r_a_u;
        r_b_t2  <= r_a_t2;
        r_b_u2  <= r_a_u2;
        r_b_t3  <= w_t3[FB+QW-1:FB];
        r_b_u3  <= w_u3[FB+QW-1:FB];
        r_c_t   <= r_b_t;
        r_c_pr  <= w_pr[FB+QW-1:FB];
        r_c_pg  <= w_pg[FB+QW-1:FB];
        r_c_pb  <= w_pb[FB+QW-1:FB];
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_valid = r_vld[3];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

### rtl/iteration_count_colormap.sv
// ----------------------------------------------------------------------------
// iteration_count_colormap
// Escape-time iteration count to RGB pixel, linear or smooth palette.
// ----------------------------------------------------------------------------
// Takes one count per clock and returns its pixel on o_red/o_green/o_blue,
// marked by a one-cycle o_valid. The count passes through a clamp stage, a
// chain of 25 divider cells (one quotient bit each, forming
// t = count*2^24/max_iterations) and a four-stage multiplier pipeline for the
// palette. busy stays low; results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module iteration_count_colormap #(
    parameter int COUNT_BITS = icc_pkg::COUNT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [COUNT_BITS-1:0]            i_iteration_count,
    input  logic                             i_cfg_we,
    input  logic [icc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [icc_pkg::MAX_BITS-1:0]     i_cfg_data,
    output logic                             o_valid,
    output logic [7:0]                       o_red,
    output logic [7:0]                       o_green,
    output logic [7:0]                       o_blue
);

    localparam int MB    = icc_pkg::MAX_BITS;
    localparam int QW    = icc_pkg::QW;
    localparam int CELLS = icc_pkg::CELLS;
    localparam int CW    = (COUNT_BITS > MB) ? COUNT_BITS : MB;
    localparam int LAT   = CELLS + 5;

    logic [MB-1:0]      r_max_iter;
    logic               r_smooth;
    logic [MB-1:0]      w_maxi;
    logic               r_cl_valid;
    logic [MB-1:0]      r_cl_count;
    icc_pkg::t_cell_bus w_bus [CELLS];

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= icc_pkg::MAX_ITER_RST;
            r_smooth   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                icc_pkg::CFG_MAX_ITER: r_max_iter <= i_cfg_data;
                icc_pkg::CFG_SMOOTH:   r_smooth   <= i_cfg_data[0];
                default:               r_smooth   <= r_smooth;
            endcase
        end
    end

    // Treat a zero limit as one
    assign w_maxi = (r_max_iter == '0) ? MB'(1) : r_max_iter;
    assign busy   = 1'b0;

    // Clamp the count to the limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cl_valid <= 1'b0;
        end else begin
            r_cl_valid <= start;
        end
        if (CW'(i_iteration_count) > CW'(w_maxi)) begin
            r_cl_count <= w_maxi;
        end else begin
            r_cl_count <= MB'(i_iteration_count);
        end
    end

    // Divider chain: first cell takes the count, later cells the doubled rest
    icc_div_cell u_cell0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_maxi  (w_maxi),
        .i_valid (r_cl_valid),
        .i_part  ({1'b0, r_cl_count}),
        .i_quo   ('0),
        .o_bus   (w_bus[0])
    );

    for (genvar k = 1; k < CELLS; k++) begin : g_cell
        icc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_maxi  (w_maxi),
            .i_valid (w_bus[k-1].valid),
            .i_part  ({w_bus[k-1].rem, 1'b0}),
            .i_quo   (w_bus[k-1].quo),
            .o_bus   (w_bus[k])
        );
    end

    icc_poly u_poly (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_smooth (r_smooth),
        .i_valid  (w_bus[CELLS-1].valid),
        .i_t      (w_bus[CELLS-1].quo),
        .o_valid  (o_valid),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue)
    );

    // Every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_valid)
        else $error("accepted word did not emerge after fixed latency");

    // The fraction never exceeds one
    a_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bus[CELLS-1].valid |-> (w_bus[CELLS-1].quo <= QW'(1 << icc_pkg::FRAC_BITS)))
        else $error("fraction above one");

    // Smooth palette stays within its analytic peak
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_smooth) |-> (o_red <= 8'd242 && o_green <= 8'd242 && o_blue <= 8'd242))
        else $error("smooth channel above peak");

endmodule
